// ===== rtl/core/differential_drive_pd_with_wall_steering_defines.svh =====
// Assertion macros for the differential drive PD block.
// Used by the port checker; no other dependencies.
`ifndef DIFFERENTIAL_DRIVE_PD_WITH_WALL_STEERING_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_PD_WITH_WALL_STEERING_DEFINES_SVH

// Implication checked in the next cycle, muted during reset
`define DDPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Implication checked in the next cycle, also through reset
`define DDPD_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/ddpd_pkg.sv =====
// Shared types and constants for the differential drive PD block.
// No dependencies.
package ddpd_pkg;

  localparam int GAIN_W = 20;
  localparam int LVL_W  = 12;
  localparam int POS_W  = 24;
  localparam int DRV_W  = 21;
  localparam int ERR_W  = 26;
  localparam int DIF_W  = 27;
  localparam int ACC_W  = 49;
  localparam int CNT_W  = 5;
  localparam int ADDR_W = 4;

  localparam logic [ADDR_W-1:0] REG_POS_KP   = 4'd0;
  localparam logic [ADDR_W-1:0] REG_POS_KD   = 4'd1;
  localparam logic [ADDR_W-1:0] REG_ANG_KP   = 4'd2;
  localparam logic [ADDR_W-1:0] REG_ANG_KD   = 4'd3;
  localparam logic [ADDR_W-1:0] REG_WALL_KP  = 4'd4;
  localparam logic [ADDR_W-1:0] REG_WALL_KD  = 4'd5;
  localparam logic [ADDR_W-1:0] REG_IR_CTR   = 4'd6;
  localparam logic [ADDR_W-1:0] REG_WALL_THR = 4'd7;

  typedef struct packed {
    logic start;
    logic run;
  } mac_ctl_t;

endpackage

// ===== rtl/core/ddpd_pd_mac.sv =====
// Bit-serial PD multiply-accumulate: Kp*e + Kd*d, one gain bit per cycle while run is set.
// Depends on ddpd_pkg.
module ddpd_pd_mac (
  input  logic                                  clk,
  input  ddpd_pkg::mac_ctl_t                    ctl,
  input  logic signed [ddpd_pkg::ERR_W-1:0]     e_in,
  input  logic signed [ddpd_pkg::DIF_W-1:0]     d_in,
  input  logic        [ddpd_pkg::GAIN_W-1:0]    kp,
  input  logic        [ddpd_pkg::GAIN_W-1:0]    kd,
  output logic signed [ddpd_pkg::ACC_W-1:0]     acc
);

  logic        [ddpd_pkg::GAIN_W-1:0] kp_r, kd_r;
  logic signed [ddpd_pkg::ACC_W-1:0]  e_r, d_r, acc_r;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      kp_r  <= kp;
      kd_r  <= kd;
      e_r   <= ddpd_pkg::ACC_W'(e_in);
      d_r   <= ddpd_pkg::ACC_W'(d_in);
      acc_r <= '0;
    end else if (ctl.run) begin
      // add the shifted operands selected by the low gain bits, then advance
      acc_r <= acc_r + (kp_r[0] ? e_r : '0) + (kd_r[0] ? d_r : '0);
      kp_r  <= kp_r >> 1;
      kd_r  <= kd_r >> 1;
      e_r   <= e_r <<< 1;
      d_r   <= d_r <<< 1;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/differential_drive_pd_with_wall_steering.sv =====
// Differential drive PD controller with wall steering.
// Flow: after an input beat, the forward and wall PD run serially over the gain
// bits, then a load step and the serial gain bits for the angle PD, then finish.
// A new input beat is taken only in idle, once the previous result has been loaded out.
// Reset: synchronous active-low; clears handshake, PD history, gains and IR centre/threshold to defaults.
module differential_drive_pd_with_wall_steering (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ddpd_pkg::POS_W-1:0]    in_target_position,
  input  logic signed [ddpd_pkg::POS_W-1:0]    in_target_angle,
  input  logic                                 in_wall_enable,
  input  logic signed [ddpd_pkg::POS_W-1:0]    in_left_wheel_pos,
  input  logic signed [ddpd_pkg::POS_W-1:0]    in_right_wheel_pos,
  input  logic        [ddpd_pkg::LVL_W-1:0]    in_left_ir_level,
  input  logic        [ddpd_pkg::LVL_W-1:0]    in_right_ir_level,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ddpd_pkg::DRV_W-1:0]    out_left_drive,
  output logic signed [ddpd_pkg::DRV_W-1:0]    out_right_drive,
  input  logic                                 cfg_we,
  input  logic        [ddpd_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic        [ddpd_pkg::GAIN_W-1:0]   cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN1 = 4'b0010,
    ST_RUN2 = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [ddpd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ddpd_pkg::GAIN_W-1:0] pos_kp_r, pos_kd_r, ang_kp_r, ang_kd_r, wall_kp_r, wall_kd_r;
  logic [ddpd_pkg::LVL_W-1:0]  ir_ctr_r, wall_thr_r;

  logic signed [24:0] last_pos_r;
  logic signed [13:0] last_wall_r;
  logic signed [25:0] last_ang_r;

  logic signed [23:0] tang_r;
  logic signed [24:0] wdiff_r;
  logic               en_r;

  logic out_valid_r;
  logic signed [ddpd_pkg::DRV_W-1:0] left_r, right_r;

  logic accept, last_bit, ang_last, load_out;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign last_bit = (cnt_r == ddpd_pkg::CNT_W'(ddpd_pkg::GAIN_W - 1));
  // angle pass spends its first cycle loading, so it ends one count later
  assign ang_last = (cnt_r == ddpd_pkg::CNT_W'(ddpd_pkg::GAIN_W));
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Error terms at accept
  logic signed [24:0] wsum, perr, wdiff;
  logic signed [23:0] mean;
  logic signed [25:0] pd;
  logic signed [13:0] le14, re14, werr;
  logic signed [14:0] wd;
  logic lwall, rwall;

  always_comb begin
    wsum  = 25'(in_left_wheel_pos) + 25'(in_right_wheel_pos);
    mean  = wsum[24:1];
    perr  = 25'(in_target_position) - 25'(mean);
    pd    = 26'(perr) - 26'(last_pos_r);
    wdiff = 25'(in_left_wheel_pos) - 25'(in_right_wheel_pos);
    le14  = 14'({2'b00, ir_ctr_r}) - 14'({2'b00, in_left_ir_level});
    re14  = 14'({2'b00, ir_ctr_r}) - 14'({2'b00, in_right_ir_level});
    lwall = in_left_ir_level < wall_thr_r;
    rwall = in_right_ir_level < wall_thr_r;
    if (lwall && rwall)      werr = le14 - re14;
    else if (lwall)          werr = le14 <<< 1;
    else if (rwall)          werr = -(re14 <<< 1);
    else                     werr = '0;
    wd = 15'(werr) - 15'(last_wall_r);
  end

  // Wall correction and angle error after the first pass
  logic signed [ddpd_pkg::ACC_W-1:0] fwd_acc, wall_acc, ang_acc;
  logic signed [ddpd_pkg::ACC_W-1:0] wall_rnd, fwd_rnd, ang_rnd, lsum, rsum;
  logic signed [10:0] corr;
  logic signed [25:0] aerr;
  logic signed [26:0] ad;

  always_comb begin
    wall_rnd = (wall_acc + ddpd_pkg::ACC_W'(128)) >>> 8;
    if (wall_rnd > ddpd_pkg::ACC_W'(800))       corr = 11'sd800;
    else if (wall_rnd < -ddpd_pkg::ACC_W'(800)) corr = -11'sd800;
    else                                        corr = wall_rnd[10:0];
    aerr = 26'(tang_r) - 26'(wdiff_r) + (en_r ? 26'(corr) : 26'sd0);
    ad   = 27'(aerr) - 27'(last_ang_r);
  end

  always_comb begin
    fwd_rnd = (fwd_acc + ddpd_pkg::ACC_W'(2048)) >>> 12;
    ang_rnd = (ang_acc + ddpd_pkg::ACC_W'(2048)) >>> 12;
    lsum    = fwd_rnd + ang_rnd;
    rsum    = fwd_rnd - ang_rnd;
  end

  function automatic logic signed [ddpd_pkg::DRV_W-1:0] sat_drv(
    input logic signed [ddpd_pkg::ACC_W-1:0] v);
    logic signed [ddpd_pkg::ACC_W-1:0] hi, lo;
    hi = ddpd_pkg::ACC_W'((1 <<< (ddpd_pkg::DRV_W - 1)) - 1);
    lo = -ddpd_pkg::ACC_W'(1 <<< (ddpd_pkg::DRV_W - 1));
    if (v > hi)      sat_drv = hi[ddpd_pkg::DRV_W-1:0];
    else if (v < lo) sat_drv = lo[ddpd_pkg::DRV_W-1:0];
    else             sat_drv = v[ddpd_pkg::DRV_W-1:0];
  endfunction

  ddpd_pkg::mac_ctl_t ctl1, ctl2;
  always_comb begin
    ctl1.start = accept;
    ctl1.run   = (state_r == ST_RUN1);
    // load the angle pass only once the wall pass has added its last bit
    ctl2.start = (state_r == ST_RUN2) && (cnt_r == '0);
    ctl2.run   = (state_r == ST_RUN2) && (cnt_r != '0);
  end

  ddpd_pd_mac u_fwd (
    .clk(clk), .ctl(ctl1), .e_in(ddpd_pkg::ERR_W'(perr)), .d_in(ddpd_pkg::DIF_W'(pd)),
    .kp(pos_kp_r), .kd(pos_kd_r), .acc(fwd_acc)
  );

  ddpd_pd_mac u_wall (
    .clk(clk), .ctl(ctl1), .e_in(ddpd_pkg::ERR_W'(werr)), .d_in(ddpd_pkg::DIF_W'(wd)),
    .kp(wall_kp_r), .kd(wall_kd_r), .acc(wall_acc)
  );

  ddpd_pd_mac u_ang (
    .clk(clk), .ctl(ctl2), .e_in(aerr), .d_in(ad),
    .kp(ang_kp_r), .kd(ang_kd_r), .acc(ang_acc)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN1;
          cnt_nxt   = '0;
        end
      end
      ST_RUN1: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_bit) begin
          state_nxt = ST_RUN2;
          cnt_nxt   = '0;
        end
      end
      ST_RUN2: begin
        cnt_nxt = cnt_r + 1'b1;
        if (ang_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      last_pos_r  <= '0;
      last_wall_r <= '0;
      last_ang_r  <= '0;
      pos_kp_r    <= 20'd70779;
      pos_kd_r    <= 20'd10035;
      ang_kp_r    <= 20'd102564;
      ang_kd_r    <= 20'd7291;
      wall_kp_r   <= 20'd82;
      wall_kd_r   <= 20'd410;
      ir_ctr_r    <= 12'd1600;
      wall_thr_r  <= 12'd2200;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (accept) begin
        last_pos_r  <= perr;
        last_wall_r <= werr;
      end
      if (ctl2.start) begin
        last_ang_r <= aerr;
      end
      if (cfg_we) begin
        case (cfg_addr)
          ddpd_pkg::REG_POS_KP:   pos_kp_r   <= cfg_wdata;
          ddpd_pkg::REG_POS_KD:   pos_kd_r   <= cfg_wdata;
          ddpd_pkg::REG_ANG_KP:   ang_kp_r   <= cfg_wdata;
          ddpd_pkg::REG_ANG_KD:   ang_kd_r   <= cfg_wdata;
          ddpd_pkg::REG_WALL_KP:  wall_kp_r  <= cfg_wdata;
          ddpd_pkg::REG_WALL_KD:  wall_kd_r  <= cfg_wdata;
          ddpd_pkg::REG_IR_CTR:   ir_ctr_r   <= cfg_wdata[ddpd_pkg::LVL_W-1:0];
          ddpd_pkg::REG_WALL_THR: wall_thr_r <= cfg_wdata[ddpd_pkg::LVL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tang_r  <= in_target_angle;
      wdiff_r <= wdiff;
      en_r    <= in_wall_enable;
    end
    if (load_out) begin
      left_r  <= sat_drv(lsum);
      right_r <= sat_drv(rsum);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;

endmodule

// ===== rtl/core/ddpd_chk.sv =====
// Port checker for the differential drive PD block, bound to the top level.
// Depends on differential_drive_pd_with_wall_steering_defines.svh.
`include "differential_drive_pd_with_wall_steering_defines.svh"

module ddpd_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a pending result beat holds until taken
  `DDPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // after an input beat the block is busy computing
  `DDPD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  // reset drops any result beat
  `DDPD_ASSERT_NEXT_ALWAYS(a_rst_clear, !rst_n, !out_valid)

endmodule

bind differential_drive_pd_with_wall_steering ddpd_chk u_ddpd_chk (.*);
